// ===== hw/rtl/tld_pkg.sv =====
package tld_pkg;

  localparam int SAMPLE_BITS    = 14;
  localparam int FRACTION_BITS  = 8;
  localparam int AVERAGE_WEIGHT = 10;
  localparam int COUNT_BITS     = 32;

  // Register fields and the elapsed tick field have fixed widths.
  localparam int REG_BITS   = 14;
  localparam int TICKS_BITS = 32;
  localparam int LEVEL_BITS = 8;

  localparam int MEAN_BITS = SAMPLE_BITS + FRACTION_BITS;

  // Divide by the averaging weight through its rounded-up reciprocal. The
  // scale leaves the error below one part in the numerator range, so the
  // truncated product is the exact quotient.
  localparam int NUM_BITS        = MEAN_BITS + $clog2(AVERAGE_WEIGHT) + 1;
  localparam int RECIP_SHIFT     = NUM_BITS + $clog2(AVERAGE_WEIGHT);
  localparam int RECIP_BITS      = NUM_BITS + 2;
  localparam int RECIP_PROD_BITS = NUM_BITS + RECIP_BITS;
  localparam logic [RECIP_BITS-1:0] RECIP_MULT =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(AVERAGE_WEIGHT) - 64'd1) / 64'(AVERAGE_WEIGHT));

  // Intensity map divider.
  localparam int MAP_BITS      = (SAMPLE_BITS > REG_BITS) ? SAMPLE_BITS : REG_BITS;
  localparam int MAP_NUM_BITS  = MAP_BITS + LEVEL_BITS;
  localparam int MAP_CNT_BITS  = $clog2(MAP_NUM_BITS);
  localparam int FULL_LEVEL    = 255;

  // Level test.
  localparam int LVL_BITS      = (MEAN_BITS > REG_BITS + FRACTION_BITS) ?
                                 MEAN_BITS : REG_BITS + FRACTION_BITS;
  localparam int LEVEL_SCALE   = 200;
  localparam int LVL_PROD_BITS = LVL_BITS + 8;

  // Configuration port.
  localparam int NUM_REGS      = 7;
  localparam int CFG_ADDR_BITS = $clog2(NUM_REGS * 4);
  localparam int CFG_DATA_BITS = 32;

  localparam logic [REG_BITS-1:0] REST_XY_RESET = REG_BITS'(8250);
  localparam logic [REG_BITS-1:0] REST_Z_RESET  = REG_BITS'(11563);
  localparam logic [REG_BITS-1:0] LOW_RESET     = REG_BITS'(5000);
  localparam logic [REG_BITS-1:0] HIGH_RESET    = REG_BITS'(12000);

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_TICK   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_REST_X = 3'd0,
    REG_REST_Y = 3'd1,
    REG_REST_Z = 3'd2,
    REG_LOW_X  = 3'd3,
    REG_HIGH_X = 3'd4,
    REG_LOW_Y  = 3'd5,
    REG_HIGH_Y = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SMOOTH,
    ST_MAP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [REG_BITS-1:0] rest;
    logic [REG_BITS-1:0] low;
    logic [REG_BITS-1:0] high;
  } axis_cfg_t;

endpackage

// ===== hw/rtl/tld_if.sv =====
interface tld_in_if import tld_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             kind;
  logic [SAMPLE_BITS-1:0] acc_x;
  logic [SAMPLE_BITS-1:0] acc_y;
  logic [SAMPLE_BITS-1:0] acc_z;

  modport source (output valid, kind, acc_x, acc_y, acc_z, input ready);
  modport sink   (input valid, kind, acc_x, acc_y, acc_z, output ready);
endinterface

interface tld_out_if import tld_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  leveled;
  logic [LEVEL_BITS-1:0] red_level;
  logic [LEVEL_BITS-1:0] blue_level;
  logic [TICKS_BITS-1:0] elapsed_ticks;

  modport source (output valid, leveled, red_level, blue_level, elapsed_ticks, input ready);
  modport sink   (input valid, leveled, red_level, blue_level, elapsed_ticks, output ready);
endinterface

// ===== hw/rtl/tld_smooth.sv =====
module tld_smooth import tld_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic [MEAN_BITS-1:0]   mean_o,
  output logic                   done_o
);

  logic [MEAN_BITS-1:0]       mean_q;
  logic                       busy_q, done_q;
  logic [NUM_BITS-1:0]        num_q;
  logic [RECIP_PROD_BITS-1:0] prod;

  // The weighted sum is registered first; the next cycle multiplies it by the
  // reciprocal of the weight and keeps the quotient bits.
  assign prod = RECIP_PROD_BITS'(num_q) * RECIP_PROD_BITS'(RECIP_MULT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
        mean_q <= prod[RECIP_SHIFT +: MEAN_BITS];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // Weighted sum with half the weight added for rounding.
      num_q <= NUM_BITS'({sample_i, {FRACTION_BITS{1'b0}}})
             + NUM_BITS'(AVERAGE_WEIGHT - 1) * NUM_BITS'(mean_q)
             + NUM_BITS'(AVERAGE_WEIGHT / 2);
    end
  end

  assign mean_o = mean_q;
  assign done_o = done_q;

endmodule

// ===== hw/rtl/tld_map.sv =====
module tld_map import tld_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [MEAN_BITS-1:0]  mean_i,
  input  axis_cfg_t             cfg_i,
  output logic [LEVEL_BITS-1:0] level_o,
  output logic                  done_o
);

  logic [MAP_BITS-1:0]     v, rest, low, high;
  logic                    in_low, in_high, at_rest;
  logic                    busy_q, done_q;
  logic [MAP_CNT_BITS-1:0] cnt_q;
  logic [MAP_NUM_BITS-1:0] num_q, num_d;
  logic [MAP_BITS-1:0]     den_q, rem_q, rem_d;
  logic [MAP_BITS:0]       trial;
  logic                    fits, last;
  logic                    divide_q, invert_q, zero_q;
  logic [LEVEL_BITS-1:0]   quot;
  logic [LEVEL_BITS-1:0]   level_q, level_d;

  assign v       = MAP_BITS'(mean_i[MEAN_BITS-1:FRACTION_BITS]);
  assign rest    = MAP_BITS'(cfg_i.rest);
  assign low     = MAP_BITS'(cfg_i.low);
  assign high    = MAP_BITS'(cfg_i.high);
  assign in_low  = (v < rest) && (v > low);
  assign in_high = (v < high) && (v > rest);
  assign at_rest = v == rest;

  assign trial = {rem_q, num_q[MAP_NUM_BITS-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign rem_d = fits ? MAP_BITS'(trial - {1'b0, den_q}) : trial[MAP_BITS-1:0];
  assign num_d = {num_q[MAP_NUM_BITS-2:0], fits};
  assign last  = cnt_q == MAP_CNT_BITS'(MAP_NUM_BITS - 1);
  // Inside an interval the quotient stays below full scale.
  assign quot  = num_d[LEVEL_BITS-1:0];

  always_comb begin
    if (divide_q) begin
      level_d = invert_q ? LEVEL_BITS'(FULL_LEVEL) - quot : quot;
    end else if (zero_q) begin
      level_d = '0;
    end else begin
      level_d = LEVEL_BITS'(FULL_LEVEL);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + MAP_CNT_BITS'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q    <= in_low ? MAP_NUM_BITS'(v - low) * MAP_NUM_BITS'(FULL_LEVEL)
                         : MAP_NUM_BITS'(v - rest) * MAP_NUM_BITS'(FULL_LEVEL);
      den_q    <= in_low ? rest - low : high - rest;
      rem_q    <= '0;
      divide_q <= in_low || in_high;
      invert_q <= in_low;
      zero_q   <= at_rest;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
      if (last) begin
        level_q <= level_d;
      end
    end
  end

  assign level_o = level_q;
  assign done_o  = done_q;

endmodule

// ===== hw/rtl/tilt_level_detector.sv =====
// Tilt level detector. A start item opens a measurement run and clears the tick
// counter; tick items count time during a run and the count saturates. Each
// sample item in a run updates three moving averages, one lane per axis. If the
// smoothed z lies within half a percent of rest_z, a leveled item with the
// elapsed ticks goes out and the run ends; otherwise an item with red and blue
// intensities mapped from the smoothed x and y goes out. Samples outside a run,
// ticks, starts and kind code 3 produce nothing. A sample in a run passes the
// averaging lanes, which divide by the weight with a reciprocal multiply, and,
// when it does not level, the bit-serial divider of the intensity maps; a new
// item is taken once the result sits in the output register. Configuration is
// by APB, register i at byte address 4*i.
module tilt_level_detector import tld_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  tld_in_if.sink                   in_i,
  tld_out_if.source                out_o
);

  logic [REG_BITS-1:0] rest_x_q, rest_y_q, rest_z_q;
  logic [REG_BITS-1:0] low_x_q, high_x_q, low_y_q, high_y_q;
  reg_idx_e            reg_idx;
  logic [REG_BITS-1:0] reg_rdata;

  state_e                state_q, state_d;
  logic                  measuring_q;
  logic [COUNT_BITS-1:0] tick_q;
  logic                  leveled_q;
  logic                  in_accept, is_start, is_tick, is_sample;
  logic                  smooth_start, map_start, load;

  logic [MEAN_BITS-1:0]  mean_x, mean_y, mean_z;
  logic                  sx_done, sy_done, sz_done;
  logic [LEVEL_BITS-1:0] red_lvl, blue_lvl;
  logic                  mx_done, my_done;
  axis_cfg_t             cfg_x, cfg_y;

  logic [LVL_BITS-1:0]   target, mz, diff;
  logic                  lvl_hit;

  logic                  out_valid_q, out_leveled_q;
  logic [LEVEL_BITS-1:0] out_red_q, out_blue_q;
  logic [TICKS_BITS-1:0] out_ticks_q;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[CFG_ADDR_BITS-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_x_q <= REST_XY_RESET;
      rest_y_q <= REST_XY_RESET;
      rest_z_q <= REST_Z_RESET;
      low_x_q  <= LOW_RESET;
      high_x_q <= HIGH_RESET;
      low_y_q  <= LOW_RESET;
      high_y_q <= HIGH_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_REST_X: rest_x_q <= pwdata[REG_BITS-1:0];
        REG_REST_Y: rest_y_q <= pwdata[REG_BITS-1:0];
        REG_REST_Z: rest_z_q <= pwdata[REG_BITS-1:0];
        REG_LOW_X:  low_x_q  <= pwdata[REG_BITS-1:0];
        REG_HIGH_X: high_x_q <= pwdata[REG_BITS-1:0];
        REG_LOW_Y:  low_y_q  <= pwdata[REG_BITS-1:0];
        REG_HIGH_Y: high_y_q <= pwdata[REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_REST_X: reg_rdata = rest_x_q;
      REG_REST_Y: reg_rdata = rest_y_q;
      REG_REST_Z: reg_rdata = rest_z_q;
      REG_LOW_X:  reg_rdata = low_x_q;
      REG_HIGH_X: reg_rdata = high_x_q;
      REG_LOW_Y:  reg_rdata = low_y_q;
      REG_HIGH_Y: reg_rdata = high_y_q;
      default:    reg_rdata = '0;
    endcase
  end

  assign prdata = CFG_DATA_BITS'(reg_rdata);

  // Item decode.
  assign in_i.ready = state_q == ST_IDLE;
  assign in_accept  = in_i.valid && in_i.ready;
  assign is_start   = in_accept && (in_i.kind == KIND_START);
  assign is_tick    = in_accept && (in_i.kind == KIND_TICK);
  assign is_sample  = in_accept && (in_i.kind == KIND_SAMPLE);

  // Averaging lanes.
  tld_smooth u_smooth_x (
    .clk_i, .rst_ni, .start_i(smooth_start), .sample_i(in_i.acc_x),
    .mean_o(mean_x), .done_o(sx_done)
  );
  tld_smooth u_smooth_y (
    .clk_i, .rst_ni, .start_i(smooth_start), .sample_i(in_i.acc_y),
    .mean_o(mean_y), .done_o(sy_done)
  );
  tld_smooth u_smooth_z (
    .clk_i, .rst_ni, .start_i(smooth_start), .sample_i(in_i.acc_z),
    .mean_o(mean_z), .done_o(sz_done)
  );

  // Intensity lanes.
  assign cfg_x = '{rest: rest_x_q, low: low_x_q, high: high_x_q};
  assign cfg_y = '{rest: rest_y_q, low: low_y_q, high: high_y_q};

  tld_map u_map_x (
    .clk_i, .rst_ni, .start_i(map_start), .mean_i(mean_x), .cfg_i(cfg_x),
    .level_o(red_lvl), .done_o(mx_done)
  );
  tld_map u_map_y (
    .clk_i, .rst_ni, .start_i(map_start), .mean_i(mean_y), .cfg_i(cfg_y),
    .level_o(blue_lvl), .done_o(my_done)
  );

  // Level test on the freshly updated z mean.
  assign target  = LVL_BITS'({rest_z_q, {FRACTION_BITS{1'b0}}});
  assign mz      = LVL_BITS'(mean_z);
  assign diff    = (mz >= target) ? mz - target : target - mz;
  assign lvl_hit = LVL_PROD_BITS'(diff) * LVL_PROD_BITS'(LEVEL_SCALE)
                   <= LVL_PROD_BITS'(target);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (is_sample && measuring_q) state_d = ST_SMOOTH;
      end
      ST_SMOOTH: begin
        if (sz_done) state_d = lvl_hit ? ST_DONE : ST_MAP;
      end
      ST_MAP: begin
        if (mx_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    smooth_start = 1'b0;
    map_start    = 1'b0;
    load         = 1'b0;
    unique case (state_q)
      ST_IDLE:   smooth_start = is_sample && measuring_q;
      ST_SMOOTH: map_start    = sz_done && !lvl_hit;
      ST_MAP:    ;
      ST_DONE:   load         = !out_valid_q || out_o.ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      measuring_q <= 1'b0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (is_start) begin
        measuring_q <= 1'b1;
        tick_q      <= '0;
      end else if (is_tick && measuring_q && (tick_q != {COUNT_BITS{1'b1}})) begin
        tick_q <= tick_q + COUNT_BITS'(1);
      end else if (state_q == ST_SMOOTH && sz_done && lvl_hit) begin
        measuring_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SMOOTH && sz_done) begin
      leveled_q <= lvl_hit;
    end
    if (load) begin
      out_leveled_q <= leveled_q;
      out_red_q     <= leveled_q ? '0 : red_lvl;
      out_blue_q    <= leveled_q ? '0 : blue_lvl;
      out_ticks_q   <= leveled_q ? TICKS_BITS'(tick_q) : '0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.leveled       = out_leveled_q;
  assign out_o.red_level     = out_red_q;
  assign out_o.blue_level    = out_blue_q;
  assign out_o.elapsed_ticks = out_ticks_q;

  // The three averaging lanes run in lockstep, as do the two map lanes.
  a_smooth_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sx_done == sz_done) && (sy_done == sz_done))
    else $error("averaging lanes out of step");

  a_map_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mx_done == my_done)
    else $error("map lanes out of step");

  a_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_sample && measuring_q |=> state_q == ST_SMOOTH)
    else $error("sample in a run did not start the lanes");

  a_level_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SMOOTH && sz_done && lvl_hit |=> !measuring_q)
    else $error("run still open after leveling");

  a_ticks_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !is_start |=> tick_q >= $past(tick_q))
    else $error("tick count went down without a start");

endmodule

// ===== tb/sv/tilt_level_detector_test.sv =====
`timescale 1ns / 100ps

module tilt_level_detector_test;
  import tld_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 10;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 80;
  localparam int LONG_HOLD     = 400;
  localparam int SHOWN_ERRORS  = 10;
  localparam int PHASES        = 4;
  localparam int PHASE_ITEMS   = 120;
  localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
  localparam int REG_MAX       = (1 << REG_BITS) - 1;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]             kind;
    logic [SAMPLE_BITS-1:0] acc_x;
    logic [SAMPLE_BITS-1:0] acc_y;
    logic [SAMPLE_BITS-1:0] acc_z;
  } tilt_item_t;

  typedef struct packed {
    logic                  leveled;
    logic [LEVEL_BITS-1:0] red_level;
    logic [LEVEL_BITS-1:0] blue_level;
    logic [TICKS_BITS-1:0] elapsed_ticks;
  } tilt_result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  tld_in_if  in_if ();
  tld_out_if out_if ();

  tilt_level_detector dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  // Shadow of the block: registers, smoothed axes and the run timer.
  logic [REG_BITS-1:0]   shadow_reg [NUM_REGS];
  logic [MEAN_BITS-1:0]  avg_x;
  logic [MEAN_BITS-1:0]  avg_y;
  logic [MEAN_BITS-1:0]  avg_z;
  logic                  run_active;
  logic [COUNT_BITS-1:0] run_ticks;

  tilt_result_t expected_results [$];
  tilt_item_t   pending_items [$];

  int   mismatches;
  int   results_seen;
  int   phase_count;
  logic in_taken;
  int   burst_left;
  int   gap_left;
  int   hold_left;
  bit   long_hold_done;
  int   rx_mode;
  int   rx_mode_left;
  int   rx_phase;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  function automatic logic [MEAN_BITS-1:0] smoothed(input logic [MEAN_BITS-1:0] mean,
                                                     input logic [SAMPLE_BITS-1:0] s);
    logic [63:0] sum;
    sum = (64'(s) << FRACTION_BITS) + 64'(AVERAGE_WEIGHT - 1) * 64'(mean)
          + 64'(AVERAGE_WEIGHT / 2);
    return MEAN_BITS'(sum / 64'(AVERAGE_WEIGHT));
  endfunction

  function automatic logic [LEVEL_BITS-1:0] tilt_intensity(input logic [MEAN_BITS-1:0] mean,
                                                           input logic [REG_BITS-1:0] rest,
                                                           input logic [REG_BITS-1:0] low,
                                                           input logic [REG_BITS-1:0] high);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] lo;
    logic [63:0] hi;
    v  = 64'(mean >> FRACTION_BITS);
    r  = 64'(rest);
    lo = 64'(low);
    hi = 64'(high);
    if (v < r && v > lo)
      return LEVEL_BITS'(64'(FULL_LEVEL) - ((v - lo) * 64'(FULL_LEVEL)) / (r - lo));
    if (v < hi && v > r) return LEVEL_BITS'(((v - r) * 64'(FULL_LEVEL)) / (hi - r));
    if (v == r) return '0;
    return LEVEL_BITS'(FULL_LEVEL);
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS) $display("mismatch: %s", msg);
  endtask

  task automatic apply_item(input tilt_item_t entry);
    logic [63:0]  target;
    logic [63:0]  offset;
    tilt_result_t res;
    if (entry.kind == KIND_START) begin
      run_active = 1'b1;
      run_ticks  = '0;
    end else if (entry.kind == KIND_TICK) begin
      if (run_active && run_ticks != '1) run_ticks = run_ticks + COUNT_BITS'(1);
    end else if (entry.kind == KIND_SAMPLE && run_active) begin
      avg_x  = smoothed(avg_x, entry.acc_x);
      avg_y  = smoothed(avg_y, entry.acc_y);
      avg_z  = smoothed(avg_z, entry.acc_z);
      target = 64'(shadow_reg[REG_REST_Z]) << FRACTION_BITS;
      offset = (64'(avg_z) >= target) ? 64'(avg_z) - target : target - 64'(avg_z);
      if (64'(LEVEL_SCALE) * offset <= target) begin
        run_active        = 1'b0;
        res.leveled       = 1'b1;
        res.red_level     = '0;
        res.blue_level    = '0;
        res.elapsed_ticks = TICKS_BITS'(run_ticks);
      end else begin
        res.leveled       = 1'b0;
        res.red_level     = tilt_intensity(avg_x, shadow_reg[REG_REST_X],
                                           shadow_reg[REG_LOW_X], shadow_reg[REG_HIGH_X]);
        res.blue_level    = tilt_intensity(avg_y, shadow_reg[REG_REST_Y],
                                           shadow_reg[REG_LOW_Y], shadow_reg[REG_HIGH_Y]);
        res.elapsed_ticks = '0;
      end
      expected_results.push_back(res);
    end
  endtask

  // Results are checked before the accepted item of the same edge is predicted.
  always @(posedge clk_i) begin
    tilt_result_t seen;
    tilt_result_t want;
    tilt_item_t   taken;
    in_taken <= in_if.valid && in_if.ready;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        seen.leveled       = out_if.leveled;
        seen.red_level     = out_if.red_level;
        seen.blue_level    = out_if.blue_level;
        seen.elapsed_ticks = out_if.elapsed_ticks;
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result leveled=%0d red=%0d blue=%0d ticks=%0d",
                                  seen.leveled, seen.red_level, seen.blue_level,
                                  seen.elapsed_ticks));
        end else begin
          want = expected_results.pop_front();
          if (seen.leveled !== want.leveled || seen.red_level !== want.red_level ||
              seen.blue_level !== want.blue_level ||
              seen.elapsed_ticks !== want.elapsed_ticks) begin
            note_mismatch($sformatf({"expected leveled=%0d red=%0d blue=%0d ticks=%0d, ",
                                     "got leveled=%0d red=%0d blue=%0d ticks=%0d"},
                                    want.leveled, want.red_level, want.blue_level,
                                    want.elapsed_ticks, seen.leveled, seen.red_level,
                                    seen.blue_level, seen.elapsed_ticks));
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        taken.kind  = in_if.kind;
        taken.acc_x = in_if.acc_x;
        taken.acc_y = in_if.acc_y;
        taken.acc_z = in_if.acc_z;
        apply_item(taken);
      end
    end
  end

  // Sender: bursts of items separated by random gaps.
  always @(negedge clk_i) begin
    tilt_item_t nxt;
    logic       offer;
    offer = in_if.valid && !in_taken;
    if (rst_ni && !offer) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() != 0) begin
        nxt = pending_items.pop_front();
        in_if.kind  <= nxt.kind;
        in_if.acc_x <= nxt.acc_x;
        in_if.acc_y <= nxt.acc_y;
        in_if.acc_z <= nxt.acc_z;
        offer = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    in_if.valid <= offer;
  end

  // Receiver: a changing stall pattern, and once a long hold-off while the
  // sender still has plenty to offer, so that the block backs up.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 40 && pending_items.size() > 50) begin
      long_hold_done = 1'b1;
      hold_left      = LONG_HOLD;
      out_if.ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(32, 256);
      end else begin
        rx_mode_left--;
      end
      rx_phase++;
      case (rx_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom_range(0, 1));
        2: out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= (rx_phase % 3) != 0;
      endcase
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("tilt_level_detector_test NOT OK");
    $finish;
  end

  task automatic cfg_write(input reg_idx_e idx, input logic [REG_BITS-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_BITS'(4 * idx);
    pwdata  <= CFG_DATA_BITS'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_reg[idx] = value;
  endtask

  task automatic verify_register(input reg_idx_e idx);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_BITS'(4 * idx);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== CFG_DATA_BITS'(shadow_reg[idx]))
      note_mismatch($sformatf("register %s expected %0d got %0d", idx.name(),
                              shadow_reg[idx], prdata));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_settings(input int phase);
    logic [REG_BITS-1:0] vals [NUM_REGS];
    int                  rest;
    if (phase == 1) begin
      vals[REG_REST_X] = REG_BITS'(1);
      vals[REG_REST_Y] = REG_BITS'(REG_MAX - 1);
      vals[REG_REST_Z] = REG_BITS'(REG_MAX);
      vals[REG_LOW_X]  = '0;
      vals[REG_HIGH_X] = REG_BITS'(REG_MAX);
      vals[REG_LOW_Y]  = '0;
      vals[REG_HIGH_Y] = REG_BITS'(REG_MAX);
    end else if (phase == 2) begin
      // Bounds swapped so that neither interval of the map exists.
      vals[REG_REST_X] = REG_BITS'(REG_MAX - 1);
      vals[REG_REST_Y] = REG_BITS'(1);
      vals[REG_REST_Z] = REG_BITS'(1);
      vals[REG_LOW_X]  = REG_BITS'(REG_MAX);
      vals[REG_HIGH_X] = '0;
      vals[REG_LOW_Y]  = REG_BITS'(REG_MAX);
      vals[REG_HIGH_Y] = '0;
    end else begin
      rest = $urandom_range(2, REG_MAX - 2);
      vals[REG_REST_X] = REG_BITS'(rest);
      vals[REG_LOW_X]  = REG_BITS'($urandom_range(0, rest - 1));
      vals[REG_HIGH_X] = REG_BITS'($urandom_range(rest + 1, REG_MAX));
      rest = $urandom_range(2, REG_MAX - 2);
      vals[REG_REST_Y] = REG_BITS'(rest);
      vals[REG_LOW_Y]  = REG_BITS'($urandom_range(0, rest - 1));
      vals[REG_HIGH_Y] = REG_BITS'($urandom_range(rest + 1, REG_MAX));
      vals[REG_REST_Z] = REG_BITS'($urandom_range(1, REG_MAX));
    end
    for (int i = 0; i < NUM_REGS; i++) cfg_write(reg_idx_e'(i), vals[i]);
    for (int i = 0; i < NUM_REGS; i++) verify_register(reg_idx_e'(i));
  endtask

  task automatic queue_item(input logic [1:0] kind, input logic [SAMPLE_BITS-1:0] x,
                            input logic [SAMPLE_BITS-1:0] y, input logic [SAMPLE_BITS-1:0] z);
    tilt_item_t entry;
    entry.kind  = kind;
    entry.acc_x = x;
    entry.acc_y = y;
    entry.acc_z = z;
    pending_items.push_back(entry);
    phase_count++;
  endtask

  task automatic queue_plain(input logic [1:0] kind);
    queue_item(kind, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
  endtask

  function automatic logic [SAMPLE_BITS-1:0] near(input int centre, input int spread);
    int v;
    v = centre + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return SAMPLE_BITS'(v);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] axis_value(input int mode,
                                                        input logic [REG_BITS-1:0] rest,
                                                        input logic [REG_BITS-1:0] low,
                                                        input logic [REG_BITS-1:0] high);
    case (mode)
      0: return SAMPLE_BITS'($urandom);
      1: return near(int'(rest), 1);
      2: return near(int'(low), 40);
      3: return near(int'(high), 40);
      4: return ($urandom_range(0, 1) == 1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
      default: return SAMPLE_BITS'($urandom_range(32'(low), 32'(high)));
    endcase
  endfunction

  // A measurement run: start, ticks and samples whose z mostly settles near
  // rest_z, so that the run ends leveled once the average has caught up.
  task automatic queue_run();
    int samples;
    int far_samples;
    int mode_x;
    int mode_y;
    int tol;
    logic [SAMPLE_BITS-1:0] z;
    samples     = $urandom_range(4, 70);
    far_samples = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    mode_x      = $urandom_range(0, 5);
    mode_y      = $urandom_range(0, 5);
    tol         = int'(shadow_reg[REG_REST_Z]) / 400;
    queue_plain(KIND_START);
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(20, 120)) queue_plain(KIND_TICK);
    for (int i = 0; i < samples; i++) begin
      repeat ($urandom_range(0, 2)) queue_plain(KIND_TICK);
      z = (i < far_samples) ? SAMPLE_BITS'($urandom)
                            : near(int'(shadow_reg[REG_REST_Z]), tol);
      queue_item(KIND_SAMPLE,
                 axis_value(mode_x, shadow_reg[REG_REST_X], shadow_reg[REG_LOW_X],
                            shadow_reg[REG_HIGH_X]),
                 axis_value(mode_y, shadow_reg[REG_REST_Y], shadow_reg[REG_LOW_Y],
                            shadow_reg[REG_HIGH_Y]),
                 z);
    end
  endtask

  task automatic queue_mix(input int total);
    while (phase_count < total) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 6)) queue_plain(2'($urandom_range(0, 3)));
        1: begin
          queue_plain(KIND_START);
          repeat ($urandom_range(0, 3)) queue_plain(KIND_TICK);
        end
        2: repeat ($urandom_range(1, 3)) queue_plain(KIND_SAMPLE);
        default: queue_run();
      endcase
    end
  endtask

  task automatic queue_directed();
    queue_item(KIND_SAMPLE, '0, SAMPLE_BITS'(SAMPLE_MAX), '0);   // sample outside a run
    queue_plain(KIND_TICK);                                      // tick outside a run
    queue_item(KIND_SPARE, SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MAX),
               SAMPLE_BITS'(SAMPLE_MAX));
    queue_plain(KIND_START);
    queue_plain(KIND_TICK);
    queue_plain(KIND_TICK);
    queue_item(KIND_SAMPLE, '0, '0, '0);
    queue_item(KIND_SAMPLE, SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MAX),
               SAMPLE_BITS'(SAMPLE_MAX));
    queue_item(KIND_SPARE, '0, '0, '0);
    queue_plain(KIND_START);                                     // restart mid-run
    queue_plain(KIND_TICK);
    queue_item(KIND_SAMPLE, LOW_RESET, HIGH_RESET, REST_Z_RESET);
    queue_item(KIND_SAMPLE, REST_XY_RESET, REST_XY_RESET, REST_Z_RESET);
    queue_item(KIND_SAMPLE, SAMPLE_BITS'(SAMPLE_MAX), '0, SAMPLE_BITS'(SAMPLE_MAX));
    queue_item(KIND_SAMPLE, '0, SAMPLE_BITS'(SAMPLE_MAX), '0);
  endtask

  // Wait until the block is idle: everything sent, every result back, and
  // time for an item that yields nothing to finish.
  task automatic drain();
    while (pending_items.size() != 0 || in_if.valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_if.valid    = 1'b0;
    in_if.kind     = '0;
    in_if.acc_x    = '0;
    in_if.acc_y    = '0;
    in_if.acc_z    = '0;
    out_if.ready   = 1'b0;
    in_taken       = 1'b0;
    mismatches     = 0;
    results_seen   = 0;
    burst_left     = 0;
    gap_left       = 0;
    hold_left      = 0;
    long_hold_done = 1'b0;
    rx_mode        = 0;
    rx_mode_left   = 0;
    rx_phase       = 0;
    shadow_reg[REG_REST_X] = REST_XY_RESET;
    shadow_reg[REG_REST_Y] = REST_XY_RESET;
    shadow_reg[REG_REST_Z] = REST_Z_RESET;
    shadow_reg[REG_LOW_X]  = LOW_RESET;
    shadow_reg[REG_HIGH_X] = HIGH_RESET;
    shadow_reg[REG_LOW_Y]  = LOW_RESET;
    shadow_reg[REG_HIGH_Y] = HIGH_RESET;
    avg_x      = '0;
    avg_y      = '0;
    avg_z      = '0;
    run_active = 1'b0;
    run_ticks  = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    for (int phase = 0; phase < PHASES; phase++) begin
      phase_count = 0;
      if (phase == 0) queue_directed();
      else load_settings(phase);
      queue_mix(PHASE_ITEMS);
      drain();
    end
    if (expected_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatches == 0) begin
      $display("tilt_level_detector_test OK");
    end else begin
      $display("tilt_level_detector_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tld_pkg.sv
hw/rtl/tld_if.sv
hw/rtl/tld_smooth.sv
hw/rtl/tld_map.sv
hw/rtl/tilt_level_detector.sv
tb/sv/tilt_level_detector_test.sv
